### design/cdq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the circular deque.
// No dependencies; every other file of the block imports this package.
package cdq_pkg;

    localparam int DATA_W    = 32;
    localparam int KIND_W    = 3;
    localparam int STAT_W    = 2;
    localparam int CAP_W     = 5;
    localparam int OCC_W     = 5;
    localparam int DEPTH_DEF = 16;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd10;

    // Operation codes carried in the kind field
    typedef enum logic [KIND_W-1:0] {
        K_PUSH_FRONT = 3'd0,
        K_PUSH_REAR  = 3'd1,
        K_POP_FRONT  = 3'd2,
        K_POP_REAR   = 3'd3,
        K_PEEK_FRONT = 3'd4,
        K_PEEK_REAR  = 3'd5
    } t_kind;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Command broadcast from the controller to every cell
    typedef struct packed {
        logic                     push_front;
        logic                     push_rear;
        logic                     pop_front;
        logic signed [DATA_W-1:0] value;
    } t_cell_ctl;

endpackage

### design/cdq_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the circular deque: operation in,
// result out, capacity write. Depends on cdq_pkg.

interface cdq_op_if;
    import cdq_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] value;
    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface cdq_res_if;
    import cdq_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] data_out;
    logic [STAT_W-1:0]        status;
    logic [OCC_W-1:0]         occupancy;
    modport source (output valid, output data_out, output status, output occupancy,
                    input ready);
    modport sink   (input valid, input data_out, input status, input occupancy,
                    output ready);
endinterface

interface cdq_cfg_if;
    import cdq_pkg::*;
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] capacity_in_use;
    modport source (output valid, output capacity_in_use, input ready);
    modport sink   (input valid, input capacity_in_use, output ready);
endinterface

### design/cdq_cell.sv
`timescale 1ns / 1ps
// One storage cell of the deque chain: holds one entry and trades it with
// its neighbors on front pushes and pops. Depends on cdq_pkg.
module cdq_cell #(
    parameter int DEPTH    = cdq_pkg::DEPTH_DEF,
    parameter int CELL_IDX = 0
) (
    input  logic                             i_clk,
    input  cdq_pkg::t_cell_ctl               i_ctl,
    input  logic [$clog2(DEPTH+1)-1:0]       i_count,
    input  logic signed [cdq_pkg::DATA_W-1:0] i_left,
    input  logic signed [cdq_pkg::DATA_W-1:0] i_right,
    output logic signed [cdq_pkg::DATA_W-1:0] o_data
);
    import cdq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;
    logic                     w_at_rear;

    // This cell is the first free slot behind the rear entry
    assign w_at_rear = (i_count == CNT_W'(CELL_IDX));

    // Shift toward the rear on front push, toward the front on front pop,
    // load at the free slot on rear push, otherwise hold
    always_comb begin
        n_data = r_data;
        if (i_ctl.push_front) begin
            n_data = i_left;
        end else if (i_ctl.pop_front) begin
            n_data = i_right;
        end else if (i_ctl.push_rear && w_at_rear) begin
            n_data = i_ctl.value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

### design/circular_deque.sv
`timescale 1ns / 1ps
// Top level of the circular deque: controller, result register and the
// chain of cdq_cell storage cells. Depends on cdq_pkg and cdq_ifs.
//
//  channel  | dir | payload                          | transfer when
//  ---------+-----+----------------------------------+--------------------
//  i_op     | in  | kind, value                      | valid && ready
//  o_res    | out | data_out, status, occupancy      | valid && ready
//  i_cfg    | in  | capacity_in_use                  | valid && ready
//
// The cells update and the result is registered at the edge of the operation's
// transfer, so one operation per cycle is taken while the consumer keeps up.
// i_op stalls only while a result waits in the output register and o_res.ready
// is low. Reset empties the deque and sets the capacity to 10; a capacity write
// empties the deque too. Entries sit front-first in the cells; front pushes and
// pops shift the chain.
module circular_deque #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    cdq_op_if.sink           i_op,
    cdq_res_if.source        o_res,
    cdq_cfg_if.sink          i_cfg
);
    import cdq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);

    logic [CAP_W-1:0]          r_cap;
    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_count;
    logic                      r_out_valid;
    logic signed [DATA_W-1:0]  r_out_data;
    logic [STAT_W-1:0]         r_out_status;
    logic [OCC_W-1:0]          r_out_occ;
    logic signed [DATA_W-1:0]  n_out_data;
    t_status                   n_out_status;

    logic [CNT_W-1:0]          w_eff_cap;
    logic                      w_full;
    logic                      w_empty;
    logic                      w_op_xfer;
    logic                      w_cfg_xfer;
    logic [IDX_W-1:0]          w_rear_idx;
    t_cell_ctl                 w_ctl;
    logic signed [DATA_W-1:0]  w_cell_data [DEPTH];

    // Clamp the capacity register into 1..DEPTH
    always_comb begin
        if (r_cap == '0) begin
            w_eff_cap = CNT_W'(1);
        end else if (int'(r_cap) > DEPTH) begin
            w_eff_cap = CNT_W'(DEPTH);
        end else begin
            w_eff_cap = CNT_W'(r_cap);
        end
    end

    assign w_full     = (r_count >= w_eff_cap);
    assign w_empty    = (r_count == '0);
    assign i_op.ready = !r_out_valid || o_res.ready;
    assign i_cfg.ready = 1'b1;
    assign w_op_xfer  = i_op.valid && i_op.ready;
    assign w_cfg_xfer = i_cfg.valid && i_cfg.ready;
    assign w_rear_idx = IDX_W'(r_count - CNT_W'(1));

    // Decode the operation into a cell command, result and next count
    always_comb begin
        w_ctl            = '0;
        w_ctl.value      = i_op.value;
        n_count          = r_count;
        n_out_data       = '0;
        n_out_status     = ST_OK;
        case (i_op.kind)
            K_PUSH_FRONT, K_PUSH_REAR: begin
                if (w_full) begin
                    n_out_status = ST_FULL;
                end else begin
                    w_ctl.push_front = (i_op.kind == K_PUSH_FRONT);
                    w_ctl.push_rear  = (i_op.kind == K_PUSH_REAR);
                    n_count          = r_count + CNT_W'(1);
                end
            end
            K_POP_FRONT, K_PEEK_FRONT: begin
                if (w_empty) begin
                    n_out_status = ST_EMPTY;
                end else begin
                    n_out_data = w_cell_data[0];
                    if (i_op.kind == K_POP_FRONT) begin
                        w_ctl.pop_front = 1'b1;
                        n_count         = r_count - CNT_W'(1);
                    end
                end
            end
            K_POP_REAR, K_PEEK_REAR: begin
                if (w_empty) begin
                    n_out_status = ST_EMPTY;
                end else begin
                    n_out_data = w_cell_data[w_rear_idx];
                    if (i_op.kind == K_POP_REAR) begin
                        n_count = r_count - CNT_W'(1);
                    end
                end
            end
            default: begin
                n_out_status = ST_OK;
            end
        endcase
        // Gate the cell command with the transfer
        if (!w_op_xfer) begin
            w_ctl.push_front = 1'b0;
            w_ctl.push_rear  = 1'b0;
            w_ctl.pop_front  = 1'b0;
        end
    end

    // Hold capacity and occupancy; a capacity write empties the deque
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= CAP_RESET;
            r_count <= '0;
        end else if (w_cfg_xfer) begin
            r_cap   <= i_cfg.capacity_in_use;
            r_count <= '0;
        end else if (w_op_xfer) begin
            r_count <= n_count;
        end
    end

    // Result register: fill on operation transfer, drop on result transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_op_xfer) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_op_xfer) begin
            r_out_data   <= n_out_data;
            r_out_status <= n_out_status;
            r_out_occ    <= OCC_W'(32'(n_count));
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.data_out  = r_out_data;
    assign o_res.status    = r_out_status;
    assign o_res.occupancy = r_out_occ;

    // Chain of storage cells, front entry in cell zero
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [DATA_W-1:0] w_left;
        logic signed [DATA_W-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = i_op.value;
        end else begin : g_mid_l
            assign w_left = w_cell_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right = w_cell_data[g];
        end else begin : g_mid_r
            assign w_right = w_cell_data[g+1];
        end
        cdq_cell #(
            .DEPTH    (DEPTH),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_count (r_count),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_cell_data[g])
        );
    end

endmodule
